[hdl/fpcb_pkg.sv]
// Shared types and constants for the flame pixel classifier and box tracker.
// No dependencies; imported by every module under hdl.

package fpcb_pkg;

	// Register reset values
	localparam int RED_THRESHOLD_RESET = 156;
	localparam int SAT_THRESHOLD_RESET = 7;
	localparam int IMAGE_WIDTH_RESET   = 640;
	localparam int IMAGE_HEIGHT_RESET  = 480;

	localparam int COORD_BITS_DEFAULT = 12;
	localparam int QUEUE_DEPTH        = 4;

	localparam int COLOR_BITS   = 8;
	localparam int CFG_IDX_BITS = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RED_THRESHOLD = 3'd0,
		CFG_SAT_THRESHOLD = 3'd1,
		CFG_ROI_LEFT      = 3'd2,
		CFG_ROI_TOP       = 3'd3,
		CFG_ROI_RIGHT     = 3'd4,
		CFG_ROI_BOTTOM    = 3'd5,
		CFG_IMAGE_WIDTH   = 3'd6,
		CFG_IMAGE_HEIGHT  = 3'd7
	} cfg_idx_t;

	// Queue status seen by the producer and consumer
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

[hdl/fpcb_front.sv]
// Front end: region test and flame color rule, two pipeline stages.
// Depends on fpcb_pkg; feeds fpcb_queue.

module fpcb_front import fpcb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic [COORD_BITS-1:0] col,
	input  logic [COORD_BITS-1:0] row,
	input  logic                  frame_end,
	input  logic [7:0]            red_threshold,
	input  logic [7:0]            sat_threshold,
	input  logic [COORD_BITS-1:0] roi_left,
	input  logic [COORD_BITS-1:0] roi_top,
	input  logic [COORD_BITS-1:0] roi_right,
	input  logic [COORD_BITS-1:0] roi_bottom,
	input  logic [COORD_BITS:0]   image_width,
	input  logic [COORD_BITS:0]   image_height,
	input  q_status_t             q_status,
	output logic                  push,
	output logic                  flame,
	output logic [COORD_BITS-1:0] flame_col,
	output logic [COORD_BITS-1:0] flame_row,
	output logic                  flame_fend
);

	localparam int SUM_BITS  = COLOR_BITS + 2;
	localparam int LHS_BITS  = SUM_BITS + COLOR_BITS;
	localparam int P1_BITS   = 2 * COLOR_BITS;
	localparam int RHS_BITS  = P1_BITS + SUM_BITS;

	logic                  valid_s1, valid_s2;
	logic                  adv_s1, adv_s2;
	logic                  ready_s2;
	logic                  hit_s1, hit_s2;
	logic [SUM_BITS-1:0]   sum_s1;
	logic [LHS_BITS-1:0]   lhs_s1, lhs_s2;
	logic [P1_BITS-1:0]    p1_s1;
	logic [COORD_BITS-1:0] col_s1, col_s2, row_s1, row_s2;
	logic                  fend_s1, fend_s2;
	logic [RHS_BITS-1:0]   rhs_s2;
	logic [RHS_BITS-1:0]   rhs;

	logic                  in_reg, order_ok;
	logic [SUM_BITS-1:0]   sum;
	logic [SUM_BITS-1:0]   diff;

	assign ready_s2 = !valid_s2 || !q_status.full;
	assign push     = valid_s2 && !q_status.full;
	assign in_stall = valid_s1 && !ready_s2;
	assign adv_s1   = in_valid && !in_stall;
	assign adv_s2   = valid_s1 && ready_s2;

	always_comb begin
		in_reg = (col >= roi_left) && (col <= roi_right) && ({1'b0, col} < image_width) &&
			(row >= roi_top) && (row <= roi_bottom) && ({1'b0, row} < image_height);
		order_ok = (red > red_threshold) && (red >= green) && (green >= blue);
		sum  = SUM_BITS'(blue) + SUM_BITS'(green) + SUM_BITS'(red);
		// Only meaningful when blue is the minimum
		diff = sum - SUM_BITS'({blue, 1'b0}) - SUM_BITS'(blue);
	end

	// Stage 1: region, ordering, first products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s1  <= in_reg && order_ok;
			sum_s1  <= sum;
			lhs_s1  <= LHS_BITS'(diff) * LHS_BITS'(red_threshold);
			p1_s1   <= P1_BITS'(8'd255 - red) * P1_BITS'(sat_threshold);
			col_s1  <= col;
			row_s1  <= row;
			fend_s1 <= frame_end;
		end
	end

	// Stage 2: second product, then compare on the way out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			hit_s2  <= hit_s1;
			lhs_s2  <= lhs_s1;
			rhs_s2  <= RHS_BITS'(p1_s1) * RHS_BITS'(sum_s1);
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			fend_s2 <= fend_s1;
		end
	end

	assign rhs        = rhs_s2;
	assign flame      = hit_s2 && (RHS_BITS'(lhs_s2) > rhs);
	assign flame_col  = col_s2;
	assign flame_row  = row_s2;
	assign flame_fend = fend_s2;

endmodule

[hdl/fpcb_queue.sv]
// Short FIFO between the classifier front end and the tracker back end.
// Depends on fpcb_pkg for the status struct and default sizes.

module fpcb_queue import fpcb_pkg::*; #(
	parameter int WIDTH = 2 * COORD_BITS_DEFAULT + 2,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_status_t        status
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_BITS'(DEPTH));
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/fpcb_back.sv]
// Back end: bounding-box tracker and output register.
// Depends on fpcb_pkg; drains fpcb_queue.

module fpcb_back import fpcb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_status_t             q_status,
	output logic                  pop,
	input  logic                  e_flame,
	input  logic [COORD_BITS-1:0] e_col,
	input  logic [COORD_BITS-1:0] e_row,
	input  logic                  e_fend,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_flame,
	output logic                  frame_done,
	output logic                  box_valid,
	output logic [COORD_BITS-1:0] box_left,
	output logic [COORD_BITS-1:0] box_top,
	output logic [COORD_BITS-1:0] box_right,
	output logic [COORD_BITS-1:0] box_bottom
);

	logic                  any_q;
	logic [COORD_BITS-1:0] min_col_q, min_row_q, max_col_q, max_row_q;
	logic                  out_valid_q;

	logic                  any_n;
	logic [COORD_BITS-1:0] min_col_n, min_row_n, max_col_n, max_row_n;
	logic                  report;

	assign pop       = !q_status.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		any_n     = any_q || e_flame;
		min_col_n = min_col_q;
		min_row_n = min_row_q;
		max_col_n = max_col_q;
		max_row_n = max_row_q;
		if (e_flame) begin
			if (!any_q || e_col < min_col_q) min_col_n = e_col;
			if (!any_q || e_col > max_col_q) max_col_n = e_col;
			if (!any_q || e_row < min_row_q) min_row_n = e_row;
			if (!any_q || e_row > max_row_q) max_row_n = e_row;
		end
		report = e_fend && any_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q       <= 1'b0;
			min_col_q   <= '0;
			min_row_q   <= '0;
			max_col_q   <= '0;
			max_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				// Clear the tracker once the frame-end item is reported
				any_q     <= e_fend ? 1'b0 : any_n;
				min_col_q <= e_fend ? '0 : min_col_n;
				min_row_q <= e_fend ? '0 : min_row_n;
				max_col_q <= e_fend ? '0 : max_col_n;
				max_row_q <= e_fend ? '0 : max_row_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_flame   <= e_flame;
			frame_done <= e_fend;
			box_valid  <= report;
			box_left   <= report ? min_col_n : '0;
			box_top    <= report ? min_row_n : '0;
			box_right  <= report ? max_col_n : '0;
			box_bottom <= report ? max_row_n : '0;
		end
	end

`ifndef SYNTHESIS
	a_box_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && box_valid) |-> frame_done)
		else $error("box reported on an item that is not frame end");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && box_valid) |-> (box_left <= box_right && box_top <= box_bottom))
		else $error("reported box has inverted edges");

	a_no_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !box_valid) |->
		(box_left == '0 && box_top == '0 && box_right == '0 && box_bottom == '0))
		else $error("box fields not zero without a box");

	a_flame_sets_tracker: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e_flame && !e_fend) |=> any_q)
		else $error("tracker missed a flame item");

	a_tracker_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e_fend) |=> (!any_q && min_col_q == '0 && max_row_q == '0))
		else $error("tracker not cleared after frame end");
`endif

endmodule

[hdl/flame_pixel_classify_bbox_top.sv]
// Top level of the flame pixel classifier with bounding-box tracker.
// Depends on fpcb_pkg, fpcb_front, fpcb_queue and fpcb_back.

// Takes one BGR pixel per clock while in_stall is low, with its column, row and
// frame-end mark, and returns one result per pixel: the flame flag, and on the
// frame-end pixel the inclusive box of all flame pixels found since the last
// frame end. A pixel counts only inside the region of interest clamped to the
// image size. Throughput is one pixel per cycle without stalls; the path from
// input to output runs through two classifier stages, the queue and the output
// register. A four-entry queue lets the classifier keep taking pixels while the
// output is stalled, until the queue fills. Write configuration registers only while idle.

module flame_pixel_classify_bbox_top import fpcb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [((COORD_BITS + 1 > COLOR_BITS) ? COORD_BITS + 1 : COLOR_BITS) - 1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  green,
	input  logic [7:0]                  red,
	input  logic [COORD_BITS-1:0]       col,
	input  logic [COORD_BITS-1:0]       row,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_flame,
	output logic                        frame_done,
	output logic                        box_valid,
	output logic [COORD_BITS-1:0]       box_left,
	output logic [COORD_BITS-1:0]       box_top,
	output logic [COORD_BITS-1:0]       box_right,
	output logic [COORD_BITS-1:0]       box_bottom
);

	localparam int IMG_BITS = COORD_BITS + 1;
	localparam int ENTRY_W  = 2 * COORD_BITS + 2;
	localparam logic [IMG_BITS-1:0] IMG_W_RST = IMG_BITS'(IMAGE_WIDTH_RESET);
	localparam logic [IMG_BITS-1:0] IMG_H_RST = IMG_BITS'(IMAGE_HEIGHT_RESET);

	logic [7:0]            red_threshold_q, sat_threshold_q;
	logic [COORD_BITS-1:0] roi_left_q, roi_top_q, roi_right_q, roi_bottom_q;
	logic [IMG_BITS-1:0]   image_width_q, image_height_q;

	q_status_t             q_status;
	logic                  push, pop;
	logic                  f_flame, f_fend;
	logic [COORD_BITS-1:0] f_col, f_row;
	logic [ENTRY_W-1:0]    push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_threshold_q <= 8'(RED_THRESHOLD_RESET);
			sat_threshold_q <= 8'(SAT_THRESHOLD_RESET);
			roi_left_q      <= '0;
			roi_top_q       <= '0;
			roi_right_q     <= '1;
			roi_bottom_q    <= '1;
			image_width_q   <= IMG_W_RST;
			image_height_q  <= IMG_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RED_THRESHOLD: red_threshold_q <= cfg_data[7:0];
				CFG_SAT_THRESHOLD: sat_threshold_q <= cfg_data[7:0];
				CFG_ROI_LEFT:      roi_left_q      <= cfg_data[COORD_BITS-1:0];
				CFG_ROI_TOP:       roi_top_q       <= cfg_data[COORD_BITS-1:0];
				CFG_ROI_RIGHT:     roi_right_q     <= cfg_data[COORD_BITS-1:0];
				CFG_ROI_BOTTOM:    roi_bottom_q    <= cfg_data[COORD_BITS-1:0];
				CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data[IMG_BITS-1:0];
				CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[IMG_BITS-1:0];
				default: ;
			endcase
		end
	end

	fpcb_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.col          (col),
		.row          (row),
		.frame_end    (frame_end),
		.red_threshold(red_threshold_q),
		.sat_threshold(sat_threshold_q),
		.roi_left     (roi_left_q),
		.roi_top      (roi_top_q),
		.roi_right    (roi_right_q),
		.roi_bottom   (roi_bottom_q),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.q_status     (q_status),
		.push         (push),
		.flame        (f_flame),
		.flame_col    (f_col),
		.flame_row    (f_row),
		.flame_fend   (f_fend)
	);

	assign push_data = {f_flame, f_col, f_row, f_fend};

	fpcb_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_status)
	);

	fpcb_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop       (pop),
		.e_flame   (pop_data[ENTRY_W-1]),
		.e_col     (pop_data[ENTRY_W-2 -: COORD_BITS]),
		.e_row     (pop_data[COORD_BITS -: COORD_BITS]),
		.e_fend    (pop_data[0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_flame  (is_flame),
		.frame_done(frame_done),
		.box_valid (box_valid),
		.box_left  (box_left),
		.box_top   (box_top),
		.box_right (box_right),
		.box_bottom(box_bottom)
	);

endmodule
